### hdl/sfc_pkg.sv
// Shared types and constants for the streaming FIR convolver.
// No dependencies; imported by sfc_cell and streaming_fir_convolver.
package sfc_pkg;

  localparam int unsigned MAX_TAPS  = 64;
  localparam int unsigned TAP_IDX_W = $clog2(MAX_TAPS);
  localparam int unsigned TAP_CNT_W = 7;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned ACC_W     = 38;
  localparam int unsigned FRAC_W    = 15;
  localparam int unsigned CMD_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_OUT
  } state_e;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic load;   // coefficient write, qualified per cell by its select bit
    logic mul;    // register h[k] * sample
    logic upd;    // shift partial sums one cell toward the output
    logic clr;    // zero all partial sums
  } cell_ctrl_t;

endpackage

### hdl/sfc_cell.sv
// One tap cell of the transposed FIR chain: coefficient, product and partial sum.
// Depends on sfc_pkg.
module sfc_cell import sfc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic                     load_sel_i,
  input  logic                     active_i,   // tap k+1 is in use
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [ACC_W-1:0]  sum_i,      // pass value of right neighbor
  output logic signed [ACC_W-1:0]  pass_o      // sum_q + product
);

  logic signed [DATA_W-1:0] coef_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  sum_q, sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (ctrl_i.load && load_sel_i) begin
      coef_q <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= coef_q * value_i;
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clr) begin
      sum_d = '0;
    end else if (ctrl_i.upd) begin
      sum_d = active_i ? sum_i : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign pass_o = sum_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

endmodule

### hdl/streaming_fir_convolver.sv
// Top level of the streaming FIR convolver: sequencer, cell chain, rounding.
// Depends on sfc_pkg and sfc_cell.
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: command; tdata: tap_index, value
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: filtered_sample; tuser: saturated
// apb       in   psel/penable/pwrite/pready     reg 0 at 0x0: tap_count (7 bits)
//
// A sample item is processed in steps: accept + product register in every cell, partial sum
// shift through the chain, then round/saturate into the output register. Load and
// clear items complete when they are accepted.
// A finished result waits in the output register while the next item is accepted;
// the rounding step holds if that register is still full.
// Reset clears coefficients, partial sums and sets tap_count to 1.
module streaming_fir_convolver import sfc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // [5:0] tap_index, [21:6] value, [23:22] zero
  input  logic [CMD_W-1:0]     s_axis_tuser,   // [1:0] command
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,   // [15:0] filtered_sample
  output logic                 m_axis_tuser,   // [0] saturated
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned T_W = ACC_W + 1;  // headroom for the rounding add
  localparam int unsigned Y_W = T_W - FRAC_W;

  // ---------------- configuration ----------------
  logic [TAP_CNT_W-1:0] tap_count_q;
  logic                 reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_CNT_W'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      tap_count_q <= pwdata[TAP_CNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32-TAP_CNT_W){1'b0}}, tap_count_q} : '0;

  // effective tap count: zero means one, clamp at the chain length
  logic [TAP_CNT_W-1:0] taps_eff;
  always_comb begin
    if (tap_count_q == '0) begin
      taps_eff = TAP_CNT_W'(1);
    end else if (tap_count_q > TAP_CNT_W'(MAX_TAPS)) begin
      taps_eff = TAP_CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = tap_count_q;
    end
  end

  // ---------------- input decode ----------------
  logic [TAP_IDX_W-1:0]     in_idx;
  logic signed [DATA_W-1:0] in_value;
  cmd_e                     in_cmd;
  logic                     in_acc;

  assign in_idx   = s_axis_tdata[TAP_IDX_W-1:0];
  assign in_value = s_axis_tdata[TAP_IDX_W +: DATA_W];
  assign in_cmd   = cmd_e'(s_axis_tuser);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // ---------------- sequencer ----------------
  state_e     state_q, state_d;
  cell_ctrl_t ctrl;
  logic       out_free;
  logic       out_load;
  logic       out_valid_q;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && in_cmd == CMD_SAMPLE) state_d = ST_ADD;
      ST_ADD:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ctrl          = '0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          unique case (in_cmd)
            CMD_SAMPLE: ctrl.mul  = 1'b1;
            CMD_LOAD:   ctrl.load = 1'b1;
            CMD_CLEAR:  ctrl.clr  = 1'b1;
            default:    ;
          endcase
        end
      end
      ST_ADD:  ctrl.upd = 1'b1;
      ST_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- cell chain ----------------
  // pass[k] = s[k] + h[k]*x; cell k takes pass[k+1] on a shift.
  logic signed [ACC_W-1:0] pass [MAX_TAPS+1];
  assign pass[MAX_TAPS] = '0;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic sel;
    logic act;
    assign sel = (in_idx == TAP_IDX_W'(k));
    assign act = (TAP_CNT_W'(k + 1) < taps_eff);

    sfc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .load_sel_i (sel),
      .active_i   (act),
      .value_i    (in_value),
      .sum_i      (pass[k+1]),
      .pass_o     (pass[k])
    );
  end

  // ---------------- round and saturate ----------------
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [T_W-1:0]    t_rnd;
  logic signed [Y_W-1:0]    y_full;
  logic                     y_sat;
  logic signed [DATA_W-1:0] y_clip;

  always_ff @(posedge clk_i) begin
    if (ctrl.upd) begin
      acc_q <= pass[0];
    end
  end

  // add half an LSB then floor-shift: exact halves go toward +inf
  assign t_rnd  = {acc_q[ACC_W-1], acc_q} + T_W'(1 << (FRAC_W - 1));
  assign y_full = t_rnd[T_W-1:FRAC_W];
  assign y_sat  = (y_full[Y_W-1:DATA_W-1] != '0) && (y_full[Y_W-1:DATA_W-1] != '1);

  always_comb begin
    if (!y_sat) begin
      y_clip = y_full[DATA_W-1:0];
    end else if (y_full[Y_W-1]) begin
      y_clip = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y_clip = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  logic [DATA_W-1:0] out_data_q;
  logic              out_sat_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= y_clip;
      out_sat_q  <= y_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  // ---------------- assertions ----------------
  // an accepted sample item passes through ST_ADD and then reaches the rounding stage
  a_sample_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_cmd == CMD_SAMPLE) |-> ##2 (state_q == ST_OUT))
    else $error("sample item did not reach rounding stage");

  // saturation flag only with a full-scale value
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000))
    else $error("saturation flag with non-full-scale output");

  // a full, stalled output register holds the result in the rounding stage
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !m_axis_tready) |=> (state_q == ST_OUT))
    else $error("rounding stage left while output stalled");

  // no input is taken while a sample is in flight
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input ready during sample processing");

endmodule
